// ===== rtl/utcdt_pkg.sv =====
package utcdt_pkg;

	localparam int DAYS_W = 25;
	localparam int TOD_W = 17;
	localparam int SECS_W = 42;
	localparam int MAG_W = 30;

	localparam logic [15:0] YEAR_MIN = 16'd1970;
	localparam logic [16:0] DIV100_MUL = 17'd83887;
	localparam int DIV100_SHIFT = 23;
	localparam logic [25:0] EPOCH_SHIFT = 26'd719468;
	localparam logic [16:0] S_PER_DAY = 17'd86400;
	localparam logic [29:0] NS_PER_S = 30'd1000000000;
	localparam logic [34:0] SECS_MAX = 35'd18446744073;

	typedef struct packed {
		logic vld;
		logic ok;
	} utcdt_ctl_t;

	// days in month, february without leap day
	function automatic logic [4:0] month_len(input logic [7:0] month);
		logic [4:0] len;
		unique case (month)
			8'd2: len = 5'd28;
			8'd4, 8'd6, 8'd9, 8'd11: len = 5'd30;
			default: len = 5'd31;
		endcase
		return len;
	endfunction

	// day of year of the first of the month, year starting in march
	function automatic logic [8:0] month_doy(input logic [7:0] month);
		logic [8:0] doy;
		unique case (month)
			8'd3: doy = 9'd0;
			8'd4: doy = 9'd31;
			8'd5: doy = 9'd61;
			8'd6: doy = 9'd92;
			8'd7: doy = 9'd122;
			8'd8: doy = 9'd153;
			8'd9: doy = 9'd184;
			8'd10: doy = 9'd214;
			8'd11: doy = 9'd245;
			8'd12: doy = 9'd275;
			8'd1: doy = 9'd306;
			8'd2: doy = 9'd337;
			default: doy = 9'd0;
		endcase
		return doy;
	endfunction

endpackage

// ===== rtl/utc_date_time_to_unix_ns.sv =====
// utc date and time record to unix time in nanoseconds
//
// request channel: a record is taken at a rising edge with start high and
// busy low. busy is always low here, so a new request can be given in every
// cycle and the block sustains one record per clock.
// result channel: done is registered together with the stage 6 output
// registers and is high for one cycle, with time_ok and unix_time_ns valid
// in that cycle. results leave in request order. there is no back pressure:
// the receiver must take each result in the cycle it is shown.
// pipeline: stage 1 range checks and the divide by 100 of the year,
// stage 2 leap rule and day count, stage 3 seconds of the day plus days
// times 86400, stage 4 limit check and two partial products times 1e9,
// stage 5 partial product sum, stage 6 signed nanosecond correction with
// carry and borrow check into the output registers.
// time_ok is low when a validity flag is missing, a field is out of range,
// or the result would leave the 64-bit range; unix_time_ns is then zero.
// reset clears the valid bits of all stages, so no done appears until a
// request has gone through; records in flight at reset are dropped.
module utc_date_time_to_unix_ns import utcdt_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [7:0]  valid_flags,
	input  logic [15:0] year,
	input  logic [7:0]  month,
	input  logic [7:0]  day,
	input  logic [7:0]  hour,
	input  logic [7:0]  minute,
	input  logic [7:0]  second,
	input  logic signed [31:0] nano_fraction,
	output logic        done,
	output logic        time_ok,
	output logic [63:0] unix_time_ns
);

	localparam int LATENCY = 6;

	logic accept;

	// fully pipelined, never stalls
	assign busy = 1'b0;
	assign accept = start && !busy;

	// date part: stages 1 and 2
	utcdt_ctl_t        date_ctl_s2;
	logic [DAYS_W-1:0] days_s2;

	utcdt_civil_days u_civil_days (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_vld  (accept),
		.year    (year),
		.month   (month),
		.day     (day),
		.ctl_s2  (date_ctl_s2),
		.days_s2 (days_s2)
	);

	// stage 1: time of day, flags, correction magnitude
	logic [TOD_W-1:0] tod;
	logic [31:0]      mag_full;
	logic             neg;
	logic             time_fields_ok;

	assign tod = 17'(hour) * 17'd3600 + 17'(minute) * 17'd60 + 17'(second);
	assign neg = nano_fraction[31];
	assign mag_full = neg ? (~nano_fraction + 32'd1) : nano_fraction;
	assign time_fields_ok = (valid_flags[1:0] == 2'b11) && (hour <= 8'd23) &&
		(minute <= 8'd59) && (second <= 8'd59) && (mag_full < {2'b00, NS_PER_S});

	logic             tok_s1;
	logic [TOD_W-1:0] tod_s1;
	logic             neg_s1;
	logic [MAG_W-1:0] mag_s1;

	always_ff @(posedge clk) begin
		tok_s1 <= time_fields_ok;
		tod_s1 <= tod;
		neg_s1 <= neg;
		mag_s1 <= mag_full[MAG_W-1:0];
	end

	// stage 2: align with the day count
	logic             tok_s2;
	logic [TOD_W-1:0] tod_s2;
	logic             neg_s2;
	logic [MAG_W-1:0] mag_s2;

	always_ff @(posedge clk) begin
		tok_s2 <= tok_s1;
		tod_s2 <= tod_s1;
		neg_s2 <= neg_s1;
		mag_s2 <= mag_s1;
	end

	// stage 3: whole seconds
	logic              vld_s3;
	logic              ok_s3;
	logic [SECS_W-1:0] secs_s3;
	logic              neg_s3;
	logic [MAG_W-1:0]  mag_s3;

	always_ff @(posedge clk) begin
		ok_s3 <= date_ctl_s2.ok && tok_s2;
		secs_s3 <= 42'(days_s2) * 42'(S_PER_DAY) + 42'(tod_s2);
		neg_s3 <= neg_s2;
		mag_s3 <= mag_s2;
	end

	// stage 4: seconds limit, split product by 1e9
	logic             vld_s4;
	logic             ok_s4;
	logic [47:0]      prod_lo_s4;
	logic [46:0]      prod_hi_s4;
	logic             neg_s4;
	logic [MAG_W-1:0] mag_s4;

	always_ff @(posedge clk) begin
		ok_s4 <= ok_s3 && (secs_s3 <= 42'(SECS_MAX));
		prod_lo_s4 <= 48'(secs_s3[17:0]) * 48'(NS_PER_S);
		prod_hi_s4 <= 47'(secs_s3[34:18]) * 47'(NS_PER_S);
		neg_s4 <= neg_s3;
		mag_s4 <= mag_s3;
	end

	// stage 5: whole nanoseconds, fits 64 bits once the limit holds
	logic             vld_s5;
	logic             ok_s5;
	logic [64:0]      whole_sum;
	logic [63:0]      whole_s5;
	logic             neg_s5;
	logic [MAG_W-1:0] mag_s5;

	assign whole_sum = {prod_hi_s4, 18'd0} + 65'(prod_lo_s4);

	always_ff @(posedge clk) begin
		ok_s5 <= ok_s4;
		whole_s5 <= whole_sum[63:0];
		neg_s5 <= neg_s4;
		mag_s5 <= mag_s4;
	end

	// stage 6: apply the correction, check borrow or carry
	logic [64:0] sub_res;
	logic [64:0] add_res;
	logic        fin_ok;
	logic [63:0] fin_val;

	assign sub_res = {1'b0, whole_s5} - 65'(mag_s5);
	assign add_res = {1'b0, whole_s5} + 65'(mag_s5);
	assign fin_ok = ok_s5 && (neg_s5 ? !sub_res[64] : !add_res[64]);
	assign fin_val = neg_s5 ? sub_res[63:0] : add_res[63:0];

	always_ff @(posedge clk) begin
		time_ok <= fin_ok;
		unix_time_ns <= fin_ok ? fin_val : 64'd0;
	end

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			done <= 1'b0;
		end else begin
			vld_s3 <= date_ctl_s2.vld;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			done <= vld_s5;
		end
	end

	// every request yields a done after the fixed latency
	a_req_to_done: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> ##LATENCY done)
		else $error("request without result");

	// no result without a request
	a_done_from_req: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(accept, LATENCY))
		else $error("result without request");

	// a failed conversion reports zero
	a_zero_on_fail: assert property (@(posedge clk) disable iff (!arst_n)
		done && !time_ok |-> unix_time_ns == 64'd0)
		else $error("nonzero time on failure");

	// ok needs both validity flags on the request
	a_ok_needs_flags: assert property (@(posedge clk) disable iff (!arst_n)
		done && time_ok |-> $past(valid_flags[1:0] == 2'b11, LATENCY))
		else $error("ok without validity flags");

endmodule

// ===== rtl/utcdt_civil_days.sv =====
module utcdt_civil_days import utcdt_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_vld,
	input  logic [15:0]       year,
	input  logic [7:0]        month,
	input  logic [7:0]        day,
	output utcdt_ctl_t        ctl_s2,
	output logic [DAYS_W-1:0] days_s2
);

	// stage 1: shifted year, divide by 100, table lookups
	logic [15:0] year_m;
	logic [32:0] qm_prod;
	logic [32:0] qy_prod;
	logic        date_ok;

	assign year_m = (month <= 8'd2) ? year - 16'd1 : year;
	assign qm_prod = {17'd0, year_m} * {16'd0, DIV100_MUL};
	assign qy_prod = {17'd0, year} * {16'd0, DIV100_MUL};
	assign date_ok = (year >= YEAR_MIN) && (month >= 8'd1) && (month <= 8'd12);

	logic        vld_s1;
	logic        ok_s1;
	logic [15:0] year_s1;
	logic [15:0] year_m_s1;
	logic [9:0]  qm_s1;
	logic [9:0]  qy_s1;
	logic [4:0]  mlen_s1;
	logic        feb_s1;
	logic [8:0]  doy_s1;
	logic [7:0]  day_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		ok_s1 <= date_ok;
		year_s1 <= year;
		year_m_s1 <= year_m;
		qm_s1 <= qm_prod[DIV100_SHIFT+9:DIV100_SHIFT];
		qy_s1 <= qy_prod[DIV100_SHIFT+9:DIV100_SHIFT];
		mlen_s1 <= month_len(month);
		feb_s1 <= (month == 8'd2);
		doy_s1 <= month_doy(month);
		day_s1 <= day;
	end

	// stage 2: leap rule, day check, day count
	logic [16:0] qy100;
	logic        leap;
	logic [4:0]  mlen_eff;
	logic        day_ok;
	logic [25:0] day_sum;

	assign qy100 = {7'd0, qy_s1} * 17'd100;
	assign leap = (year_s1[1:0] == 2'b00) &&
		(({1'b0, year_s1} != qy100) || (qy_s1[1:0] == 2'b00));
	assign mlen_eff = mlen_s1 + {4'd0, feb_s1 & leap};
	assign day_ok = (day_s1 != 8'd0) && (day_s1 <= {3'd0, mlen_eff});
	assign day_sum = 26'(year_m_s1) * 26'd365 + 26'(year_m_s1[15:2])
		- 26'(qm_s1) + 26'(qm_s1[9:2]) + 26'(doy_s1) + 26'(day_s1)
		- 26'd1 - EPOCH_SHIFT;

	logic vld_s2;
	logic ok_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		ok_s2 <= ok_s1 && day_ok;
		days_s2 <= day_sum[DAYS_W-1:0];
	end

	assign ctl_s2 = '{vld: vld_s2, ok: ok_s2};

endmodule
